>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the duty generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVA_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SVA_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/svpwm_pkg.sv
// Package with widths, constants and pipeline stage positions of the duty generator.
package svpwm_pkg;

  // Field widths.
  localparam int ANGLE_BITS   = 16;
  localparam int VOLTAGE_BITS = 16;
  localparam int CFG_BITS     = 16;
  localparam int DUTY_BITS    = 16;
  localparam int SECTOR_BITS  = 3;
  localparam int CFG_IDX_BITS = 2;

  // Square root sizing: radicand is (q^2 + d^2) << 16.
  localparam int ROOT_BITS = VOLTAGE_BITS + 8;
  localparam int RAD_BITS  = 2 * ROOT_BITS;

  // Sine lane input is a sector fraction from 0 to one full sector.
  localparam int FRAC_BITS = ANGLE_BITS + 1;
  localparam int LANE_STAGES = 9;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SUPPLY_RECIPROCAL = 2'd0,
    REG_MAGNITUDE_LIMIT   = 2'd1,
    REG_PWM_PERIOD        = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_BITS-1:0] SUPPLY_RECIP_RESET = 16'd5461;
  localparam logic [CFG_BITS-1:0] LIMIT_RESET        = 16'd37814;
  localparam logic [CFG_BITS-1:0] PERIOD_RESET       = 16'd1440;

  // Fixed-point constants.
  localparam logic [30:0] PI3_Q30   = 31'd1124419809;
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
  localparam logic [16:0] UNIT_Q16  = 17'h10000;

  // Reciprocals floor(2^32 / n) for the series divisors, with the divisors.
  localparam logic [30:0] RECIP_6    = 31'd715827882;
  localparam logic [30:0] RECIP_120  = 31'd35791394;
  localparam logic [30:0] RECIP_5040 = 31'd852176;
  localparam logic [30:0] DIV_6      = 31'd6;
  localparam logic [30:0] DIV_120    = 31'd120;
  localparam logic [30:0] DIV_5040   = 31'd5040;

  // Pipeline stage positions; stage 0 is the input register.
  localparam int ROOT_STAGE    = 1 + ROOT_BITS;
  localparam int UREF_STAGE    = ROOT_STAGE + 2;
  localparam int LANE_IN_STAGE = UREF_STAGE - LANE_STAGES;
  localparam int T_STAGE       = UREF_STAGE + 1;
  localparam int MIX_STAGE     = T_STAGE + 1;
  localparam int OUT_STAGE     = MIX_STAGE + 1;

endpackage

>>> rtl/core/svpwm_channels.sv
// Channel interfaces of the duty generator: input item, result item and configuration write.
interface svpwm_in_if;
  logic valid;
  logic ready;
  logic signed [svpwm_pkg::VOLTAGE_BITS-1:0] q_voltage;
  logic signed [svpwm_pkg::VOLTAGE_BITS-1:0] d_voltage;
  logic [svpwm_pkg::ANGLE_BITS-1:0] elec_angle;
  modport source (output valid, output q_voltage, output d_voltage, output elec_angle,
                  input ready);
  modport sink (input valid, input q_voltage, input d_voltage, input elec_angle,
                output ready);
endinterface

interface svpwm_out_if;
  logic valid;
  logic ready;
  logic [svpwm_pkg::DUTY_BITS-1:0] duty_a;
  logic [svpwm_pkg::DUTY_BITS-1:0] duty_b;
  logic [svpwm_pkg::DUTY_BITS-1:0] duty_c;
  logic [svpwm_pkg::SECTOR_BITS-1:0] sector;
  modport source (output valid, output duty_a, output duty_b, output duty_c, output sector,
                  input ready);
  modport sink (input valid, input duty_a, input duty_b, input duty_c, input sector,
                output ready);
endinterface

interface svpwm_cfg_if;
  logic valid;
  logic ready;
  logic [svpwm_pkg::CFG_IDX_BITS-1:0] index;
  logic [svpwm_pkg::CFG_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/svpwm_duty_generator_unit.sv
// Top level of the space vector PWM duty generator.
//
// Channel   Role  Moves
// pwm_in    sink  one item: q_voltage, d_voltage, elec_angle
// pwm_out   src   one item: duty_a, duty_b, duty_c, sector
// cfg       sink  register write: index, data (always ready)
//
// One item enters per cycle while the output is not stalled; each result passes the 24 stage
// square root followed by scaling and duty stages and leaves from stage OUT_STAGE. All stages
// advance together; a stalled output holds the whole pipeline.
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
module svpwm_duty_generator_unit (
  input  logic          clk,
  input  logic          rst,
  svpwm_in_if.sink      pwm_in,
  svpwm_out_if.source   pwm_out,
  svpwm_cfg_if.sink     cfg
);

  `include "assert_macros.svh"

  localparam int AB  = svpwm_pkg::ANGLE_BITS;
  localparam int VB  = svpwm_pkg::VOLTAGE_BITS;
  localparam int RB  = svpwm_pkg::ROOT_BITS;
  localparam int OS  = svpwm_pkg::OUT_STAGE;
  localparam int LS  = svpwm_pkg::LANE_IN_STAGE;
  localparam int MS  = svpwm_pkg::MIX_STAGE;
  localparam int TS  = svpwm_pkg::T_STAGE;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  // Duty value times period, with the duty clamped at one.
  function automatic logic [15:0] to_count(input logic [18:0] dv, input logic [15:0] per);
    logic [16:0] dc;
    logic [32:0] p;
    dc = (dv > 19'(svpwm_pkg::UNIT_Q16)) ? svpwm_pkg::UNIT_Q16 : dv[16:0];
    p  = 33'(dc) * 33'(per);
    return p[31:16];
  endfunction

  logic [15:0] supply_reciprocal;
  logic [15:0] magnitude_limit;
  logic [15:0] pwm_period;

  logic [OS:0] vld;
  logic        en;

  logic signed [VB-1:0] q_0, d_0;
  logic [AB-1:0]        ang_0;
  logic [2*VB-2:0]      qsq_1, dsq_1;
  logic [VB-1:0]        qa, da;
  logic [AB-1:0]        ang_s;
  logic [AB+2:0]        six;
  logic [AB-1:0]        r_d [1:LS];
  logic [2:0]           k_d [1:MS];
  logic [2*VB-1:0]      sqsum;
  logic [svpwm_pkg::RAD_BITS-1:0] rad;
  logic [RB-1:0]        root;
  logic [RB+15:0]       uprod;
  logic [RB-1:0]        uraw;
  logic [15:0]          uref;
  logic [svpwm_pkg::FRAC_BITS-1:0] frac_lo, frac_hi;
  logic [31:0]          g1, g2;
  logic [47:0]          p1, p2;
  logic [16:0]          t1, t2;
  logic [17:0]          sum;
  logic [16:0]          t0;
  logic [15:0]          h;
  logic [18:0]          a_m, b_m, c_m;

  // Configuration writes; taken whenever offered.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      supply_reciprocal <= svpwm_pkg::SUPPLY_RECIP_RESET;
      magnitude_limit   <= svpwm_pkg::LIMIT_RESET;
      pwm_period        <= svpwm_pkg::PERIOD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        svpwm_pkg::REG_SUPPLY_RECIPROCAL: supply_reciprocal <= cfg.data;
        svpwm_pkg::REG_MAGNITUDE_LIMIT:   magnitude_limit   <= cfg.data;
        svpwm_pkg::REG_PWM_PERIOD:        pwm_period        <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits.
  assign en           = !vld[OS] || pwm_out.ready;
  assign pwm_in.ready = en;
  assign pwm_out.valid = vld[OS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[OS-1:0], pwm_in.valid};
    end
  end

  // Stage 0 inputs and stage 1 squares, angle shift and sector split.
  assign qa    = q_0[VB-1] ? VB'(-q_0) : VB'(q_0);
  assign da    = d_0[VB-1] ? VB'(-d_0) : VB'(d_0);
  assign ang_s = (!q_0[VB-1] && (q_0 != '0)) ? ang_0 + QUARTER : ang_0 - QUARTER;
  assign six   = (AB + 3)'(ang_s) * (AB + 3)'(6);

  always_ff @(posedge clk) begin
    if (en) begin
      q_0   <= pwm_in.q_voltage;
      d_0   <= pwm_in.d_voltage;
      ang_0 <= pwm_in.elec_angle;
      qsq_1 <= (2 * VB - 1)'((2 * VB)'(qa) * (2 * VB)'(qa));
      dsq_1 <= (2 * VB - 1)'((2 * VB)'(da) * (2 * VB)'(da));
      r_d[1] <= six[AB-1:0];
      k_d[1] <= six[AB+2:AB];
      for (int i = 2; i <= LS; i++) r_d[i] <= r_d[i-1];
      for (int i = 2; i <= MS; i++) k_d[i] <= k_d[i-1];
    end
  end

  // Vector length through the square root pipeline.
  assign sqsum = (2 * VB)'(qsq_1) + (2 * VB)'(dsq_1);
  assign rad   = {sqsum, 16'b0};

  svpwm_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  // Supply scaling and magnitude limit.
  assign uraw = uprod[RB+15:16];
  always_ff @(posedge clk) begin
    if (en) begin
      uprod <= (RB + 16)'(root) * (RB + 16)'(supply_reciprocal);
      uref  <= (uraw > RB'(magnitude_limit)) ? magnitude_limit : uraw[15:0];
    end
  end

  // Sine lanes for the two active vector times, aligned with uref.
  assign frac_lo = svpwm_pkg::FRAC_BITS'(r_d[LS]);
  assign frac_hi = (svpwm_pkg::FRAC_BITS'(1) << AB) - frac_lo;

  svpwm_sine_lane u_sine_t1 (
    .clk  (clk),
    .en   (en),
    .frac (frac_hi),
    .gain (g1)
  );

  svpwm_sine_lane u_sine_t2 (
    .clk  (clk),
    .en   (en),
    .frac (frac_lo),
    .gain (g2)
  );

  // Active vector times in Q1.16.
  assign p1 = 48'(g1) * 48'(uref);
  assign p2 = 48'(g2) * 48'(uref);

  // Zero vector time and the centre-aligned sector table.
  assign sum = 18'(t1) + 18'(t2);
  assign t0  = (sum >= 18'(svpwm_pkg::UNIT_Q16)) ? 17'd0 : 17'(18'(svpwm_pkg::UNIT_Q16) - sum);
  assign h   = t0[16:1];

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= p1[46:30];
      t2 <= p2[46:30];
      unique case (k_d[TS])
        3'd0: begin
          a_m <= 19'(h);
          b_m <= 19'(t1) + 19'(h);
          c_m <= 19'(sum) + 19'(h);
        end
        3'd1: begin
          a_m <= 19'(t2) + 19'(h);
          b_m <= 19'(h);
          c_m <= 19'(sum) + 19'(h);
        end
        3'd2: begin
          a_m <= 19'(sum) + 19'(h);
          b_m <= 19'(h);
          c_m <= 19'(t1) + 19'(h);
        end
        3'd3: begin
          a_m <= 19'(sum) + 19'(h);
          b_m <= 19'(t2) + 19'(h);
          c_m <= 19'(h);
        end
        3'd4: begin
          a_m <= 19'(t1) + 19'(h);
          b_m <= 19'(sum) + 19'(h);
          c_m <= 19'(h);
        end
        default: begin
          a_m <= 19'(h);
          b_m <= 19'(sum) + 19'(h);
          c_m <= 19'(t2) + 19'(h);
        end
      endcase
    end
  end

  // Output register: compare values and sector number.
  always_ff @(posedge clk) begin
    if (en) begin
      pwm_out.duty_a <= to_count(a_m, pwm_period);
      pwm_out.duty_b <= to_count(b_m, pwm_period);
      pwm_out.duty_c <= to_count(c_m, pwm_period);
      pwm_out.sector <= k_d[MS] + 3'd1;
    end
  end

  // Range conditions on the delivered item.
  logic sector_ok;
  logic duty_ok;
  assign sector_ok = (pwm_out.sector >= 3'd1) && (pwm_out.sector <= 3'd6);
  assign duty_ok   = (pwm_out.duty_a <= pwm_period) && (pwm_out.duty_b <= pwm_period) &&
                     (pwm_out.duty_c <= pwm_period);

  // An accepted item always enters stage 0.
  `SVA_NEXT(a_accept_enters, pwm_in.valid && pwm_in.ready, vld[0])
  // A delivered sector lies between one and six.
  `SVA_IMPLIES(a_sector_range, pwm_out.valid, sector_ok)
  // No compare value exceeds the period.
  `SVA_IMPLIES(a_duty_bound, pwm_out.valid, duty_ok)

endmodule

>>> rtl/core/svpwm_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
module svpwm_sqrt_pipe (
  input  logic                               clk,
  input  logic                               en,
  input  logic [svpwm_pkg::RAD_BITS-1:0]     rad,
  output logic [svpwm_pkg::ROOT_BITS-1:0]    root
);

  localparam int RW = svpwm_pkg::RAD_BITS;
  localparam int NS = svpwm_pkg::ROOT_BITS;

  logic [RW-1:0] rem_q [NS];
  logic [RW-1:0] acc_q [NS];
  logic [RW-1:0] rem_src [NS];
  logic [RW-1:0] acc_src [NS];
  logic [RW-1:0] rem_next [NS];
  logic [RW-1:0] acc_next [NS];

  // Each stage tries the next bit pair of the root against the partial remainder.
  always_comb begin
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    rem_src[0] = rad;
    acc_src[0] = '0;
    for (int i = 1; i < NS; i++) begin
      rem_src[i] = rem_q[i-1];
      acc_src[i] = acc_q[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      bitv  = RW'(1) << (RW - 2 - 2 * i);
      trial = acc_src[i] + bitv;
      if (rem_src[i] >= trial) begin
        rem_next[i] = rem_src[i] - trial;
        acc_next[i] = (acc_src[i] >> 1) + bitv;
      end else begin
        rem_next[i] = rem_src[i];
        acc_next[i] = acc_src[i] >> 1;
      end
    end
  end

  // Stage registers advance together with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        rem_q[i] <= rem_next[i];
        acc_q[i] <= acc_next[i];
      end
    end
  end

  assign root = acc_q[NS-1][NS-1:0];

endmodule

>>> rtl/core/svpwm_sine_lane.sv
// Pipelined sqrt(3) * sin(frac * 60 degrees) by a seventh order series, result in Q30.
module svpwm_sine_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic [svpwm_pkg::FRAC_BITS-1:0]    frac,
  output logic [31:0]                        gain
);

  localparam int AB = svpwm_pkg::ANGLE_BITS;

  // Product of two Q30 values, shifted back to Q30.
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[60:30];
  endfunction

  // First estimate of v / n as (v * floor(2^32 / n)) >> 32, low by at most one.
  function automatic logic [30:0] div_est(input logic [30:0] v, input logic [30:0] recip);
    logic [61:0] p;
    p = 62'(v) * 62'(recip);
    return 31'(p[61:32]);
  endfunction

  // Correction of the estimate by one compare of the remainder.
  function automatic logic [30:0] div_fix(input logic [30:0] est, input logic [30:0] v,
                                          input logic [30:0] n);
    logic [30:0] rem;
    rem = v - 31'(est * n);
    return (rem >= n) ? est + 31'd1 : est;
  endfunction

  logic [AB+31:0] xprod;
  logic [30:0] x_1;
  logic [30:0] x_2, x2_2;
  logic [30:0] x_3, x2_3, x3_3;
  logic [30:0] x_4, x2_4, x3_4, x5_4, d3_4;
  logic [30:0] x_5, x5_5, x7_5, q3_5, d5_5;
  logic [30:0] acc_6, x7_6, q5_6, d7_6;
  logic [30:0] acc_7, q7_7;
  logic [30:0] s_8;
  logic [61:0] gprod;

  assign xprod = (AB + 32)'(frac) * (AB + 32)'(svpwm_pkg::PI3_Q30);
  assign gprod = 62'(s_8) * 62'(svpwm_pkg::SQRT3_Q30);

  // Powers of x, then the divided terms, then the alternating sum and the gain.
  always_ff @(posedge clk) begin
    if (en) begin
      x_1   <= xprod[AB+30:AB];
      x_2   <= x_1;
      x2_2  <= mul_q30(x_1, x_1);
      x_3   <= x_2;
      x2_3  <= x2_2;
      x3_3  <= mul_q30(x2_2, x_2);
      x_4   <= x_3;
      x2_4  <= x2_3;
      x3_4  <= x3_3;
      x5_4  <= mul_q30(x3_3, x2_3);
      d3_4  <= div_est(x3_3, svpwm_pkg::RECIP_6);
      x_5   <= x_4;
      x5_5  <= x5_4;
      x7_5  <= mul_q30(x5_4, x2_4);
      q3_5  <= div_fix(d3_4, x3_4, svpwm_pkg::DIV_6);
      d5_5  <= div_est(x5_4, svpwm_pkg::RECIP_120);
      acc_6 <= x_5 - q3_5;
      x7_6  <= x7_5;
      q5_6  <= div_fix(d5_5, x5_5, svpwm_pkg::DIV_120);
      d7_6  <= div_est(x7_5, svpwm_pkg::RECIP_5040);
      acc_7 <= acc_6 + q5_6;
      q7_7  <= div_fix(d7_6, x7_6, svpwm_pkg::DIV_5040);
      s_8   <= acc_7 - q7_7;
      gain  <= gprod[61:30];
    end
  end

endmodule
